// ===== rtl/core/kcl_pkg.sv =====
// shared types and constants for the keypad code lock
// no dependencies; imported by every other file of the block except kcl_channels

package kcl_pkg;

  // status codes of a result word
  typedef enum logic [2:0] {
    ST_NONE       = 3'd0,
    ST_KEY        = 3'd1,
    ST_RIGHT      = 3'd2,
    ST_WRONG      = 3'd3,
    ST_LOCK_START = 3'd4,
    ST_LOCK_TICK  = 3'd5,
    ST_LOCK_END   = 3'd6
  } kcl_status_t;

  // command codes of an input word
  localparam logic CMD_SCAN = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // register indexes on the configuration port
  localparam logic [1:0] REG_CODE_KEYS       = 2'd0;
  localparam logic [1:0] REG_MAX_FAILURES    = 2'd1;
  localparam logic [1:0] REG_LOCKOUT_SECONDS = 2'd2;

  localparam logic [15:0] CODE_KEYS_RESET       = 16'h4210;
  localparam logic [3:0]  MAX_FAILURES_RESET    = 4'd5;
  localparam logic [5:0]  LOCKOUT_SECONDS_RESET = 6'd30;

  localparam logic [5:0] ELAPSED_MAX = 6'd63;

  // classification queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // classified input word
  typedef struct packed {
    logic       is_tick;
    logic       key_valid;
    logic [3:0] key_pos;
  } kcl_word_t;

  // configuration registers as seen by the back end
  typedef struct packed {
    logic [15:0] code_keys;
    logic [3:0]  max_failures;
    logic [5:0]  lockout_seconds;
  } kcl_cfg_t;

endpackage

// ===== rtl/core/kcl_channels.sv =====
// valid/ready channel interfaces for the keypad code lock
// input channel carries scan words, output channel carries result words

interface kcl_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] scan_code;

  modport source (output valid, output command, output scan_code, input ready);
  modport sink (input valid, input command, input scan_code, output ready);
endinterface

interface kcl_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [3:0] key_position;
  logic [3:0] failure_count;
  logic [5:0] wait_elapsed;

  modport source (output valid, output status, output key_position,
                  output failure_count, output wait_elapsed, input ready);
  modport sink (input valid, input status, input key_position,
                input failure_count, input wait_elapsed, output ready);
endinterface

// ===== rtl/core/kcl_front.sv =====
// front end: accepts input words and decodes scan codes into key positions
// depends on kcl_pkg and kcl_in_if

module kcl_front import kcl_pkg::*; (
  kcl_in_if.sink    entry,
  input  logic      queue_full,
  output logic      push,
  output kcl_word_t push_word
);

  // one-cold nibble to index, valid flag in bit 2
  function automatic logic [2:0] cold_index(input logic [3:0] nib);
    logic [2:0] r;
    case (nib)
      4'b1110: r = 3'b100;
      4'b1101: r = 3'b101;
      4'b1011: r = 3'b110;
      4'b0111: r = 3'b111;
      default: r = 3'b000;
    endcase
    return r;
  endfunction

  logic [2:0] row;
  logic [2:0] col;

  assign row = cold_index(entry.scan_code[3:0]);
  assign col = cold_index(entry.scan_code[7:4]);

  assign entry.ready = !queue_full;
  assign push        = entry.valid && !queue_full;

  always_comb begin
    push_word.is_tick   = (entry.command == CMD_TICK);
    push_word.key_valid = row[2] && col[2];
    push_word.key_pos   = {row[1:0], col[1:0]};
  end

endmodule

// ===== rtl/core/kcl_queue.sv =====
// short queue of classified words between front and back end
// depends on kcl_pkg

module kcl_queue import kcl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  kcl_word_t push_word,
  output logic      full,
  input  logic      pop,
  output kcl_word_t pop_word,
  output logic      empty
);

  kcl_word_t                mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]   wr_ptr;
  logic [QUEUE_PTR_W-1:0]   rd_ptr;
  logic [QUEUE_CNT_W-1:0]   count;

  assign full     = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_word = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/kcl_back.sv =====
// back end: entry collection, code compare, failure count and lockout timer
// depends on kcl_pkg and kcl_out_if; result held in an output register

module kcl_back import kcl_pkg::*; #(
  parameter int CODE_LENGTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  kcl_cfg_t  cfg,
  input  logic      queue_empty,
  input  kcl_word_t word,
  output logic      pop,
  kcl_out_if.source result
);

  localparam int IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

  logic [3:0]       entered_keys [CODE_LENGTH];
  logic [IDX_W-1:0] entry_count;
  logic [3:0]       fail_counter;
  logic             locked;
  logic [5:0]       lock_elapsed;

  logic [IDX_W-1:0] entry_count_next;
  logic [3:0]       fail_counter_next;
  logic             locked_next;
  logic [5:0]       lock_elapsed_next;
  logic             store_key;
  kcl_status_t      status_next;
  logic [3:0]       key_next;
  logic [5:0]       wait_next;
  logic             match;
  logic [5:0]       elapsed_inc;
  logic [3:0]       fail_inc;

  assign pop = !queue_empty && (!result.valid || result.ready);

  // all earlier positions plus the key now arriving at the last position
  always_comb begin
    match = (word.key_pos == 4'(cfg.code_keys >> (4 * (CODE_LENGTH - 1))));
    for (int i = 0; i < CODE_LENGTH - 1; i++) begin
      if (entered_keys[i] != 4'(cfg.code_keys >> (4 * i))) begin
        match = 1'b0;
      end
    end
  end

  assign elapsed_inc = (lock_elapsed < ELAPSED_MAX) ? lock_elapsed + 6'd1 : lock_elapsed;
  assign fail_inc    = (fail_counter < 4'd15) ? fail_counter + 4'd1 : fail_counter;

  always_comb begin
    entry_count_next  = entry_count;
    fail_counter_next = fail_counter;
    locked_next       = locked;
    lock_elapsed_next = lock_elapsed;
    store_key         = 1'b0;
    status_next       = ST_NONE;
    key_next          = 4'd0;
    wait_next         = 6'd0;
    if (word.is_tick) begin
      if (locked) begin
        wait_next = elapsed_inc;
        if (elapsed_inc >= cfg.lockout_seconds) begin
          locked_next       = 1'b0;
          lock_elapsed_next = 6'd0;
          fail_counter_next = 4'd0;
          status_next       = ST_LOCK_END;
        end else begin
          lock_elapsed_next = elapsed_inc;
          status_next       = ST_LOCK_TICK;
        end
      end
    end else if (!locked && word.key_valid) begin
      key_next  = word.key_pos;
      store_key = 1'b1;
      if (entry_count != IDX_W'(CODE_LENGTH - 1)) begin
        entry_count_next = entry_count + 1'b1;
        status_next      = ST_KEY;
      end else begin
        entry_count_next = '0;
        if (match) begin
          fail_counter_next = 4'd0;
          status_next       = ST_RIGHT;
        end else begin
          fail_counter_next = fail_inc;
          if (fail_inc >= cfg.max_failures) begin
            locked_next       = 1'b1;
            lock_elapsed_next = 6'd0;
            status_next       = ST_LOCK_START;
          end else begin
            status_next = ST_WRONG;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && store_key) begin
      entered_keys[entry_count] <= word.key_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result.status        <= status_next;
      result.key_position  <= key_next;
      result.failure_count <= fail_counter_next;
      result.wait_elapsed  <= wait_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count  <= '0;
      fail_counter <= 4'd0;
      locked       <= 1'b0;
      lock_elapsed <= 6'd0;
      result.valid <= 1'b0;
    end else begin
      if (pop) begin
        entry_count  <= entry_count_next;
        fail_counter <= fail_counter_next;
        locked       <= locked_next;
        lock_elapsed <= lock_elapsed_next;
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/keypad_code_lock.sv =====
// keypad code lock: one result word per input word, scan code or second tick
// when idle, an accepted input word goes through the queue, then the output register, to its result word
// throughput: one word per cycle while the result channel is not stalled, set by the lock state update
// the two-entry queue lets input words keep flowing while a result is stalled
// reset (rst, synchronous): queue empty, entry and failure counts zero,
// unlocked, registers back to code 0x4210, five failures, thirty seconds

module keypad_code_lock import kcl_pkg::*; #(
  parameter int CODE_LENGTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  kcl_in_if.sink      entry,
  kcl_out_if.source   result,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  kcl_cfg_t   cfg;
  logic [1:0] reg_index;
  logic       cfg_write;

  logic       push;
  kcl_word_t  push_word;
  logic       queue_full;
  logic       pop;
  kcl_word_t  pop_word;
  logic       queue_empty;

  // registers on word boundaries, index from the upper address bits
  assign reg_index = paddr[3:2];
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.code_keys       <= CODE_KEYS_RESET;
      cfg.max_failures    <= MAX_FAILURES_RESET;
      cfg.lockout_seconds <= LOCKOUT_SECONDS_RESET;
    end else if (cfg_write) begin
      case (reg_index)
        REG_CODE_KEYS:       cfg.code_keys       <= pwdata[15:0];
        REG_MAX_FAILURES:    cfg.max_failures    <= pwdata[3:0];
        REG_LOCKOUT_SECONDS: cfg.lockout_seconds <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  // read back, unused addresses read zero
  always_comb begin
    case (reg_index)
      REG_CODE_KEYS:       prdata = {16'd0, cfg.code_keys};
      REG_MAX_FAILURES:    prdata = {28'd0, cfg.max_failures};
      REG_LOCKOUT_SECONDS: prdata = {26'd0, cfg.lockout_seconds};
      default:             prdata = 32'd0;
    endcase
  end

  // front: take input words and decode the scan code
  kcl_front u_front (
    .entry      (entry),
    .queue_full (queue_full),
    .push       (push),
    .push_word  (push_word)
  );

  // classified words wait here while the back end is stalled
  kcl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .full      (queue_full),
    .pop       (pop),
    .pop_word  (pop_word),
    .empty     (queue_empty)
  );

  // back: lock state update and registered result word
  kcl_back #(
    .CODE_LENGTH (CODE_LENGTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .queue_empty (queue_empty),
    .word        (pop_word),
    .pop         (pop),
    .result      (result)
  );

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the keypad code lock: scan and tick words in, status words out
// depends on kcl_pkg, the kcl_in_if / kcl_out_if channels and keypad_code_lock

module tb_top;
  import kcl_pkg::*;

  localparam int KEYS_PER_ENTRY = 4;
  localparam int PHASES         = 8;
  localparam int LIVE_PER_PHASE = 120;
  localparam int STALL_LIMIT    = 2000;
  localparam int TAIL_CYCLES    = 10;
  localparam int LONG_HOLD      = 60;

  // one result word as the block should report it
  typedef struct packed {
    kcl_status_t status;
    logic [3:0]  key_position;
    logic [3:0]  failure_count;
    logic [5:0]  wait_elapsed;
  } lock_outcome_t;

  // one input word plus the outcome it must produce
  typedef struct {
    logic          command;
    logic [7:0]    scan_code;
    lock_outcome_t outcome;
  } scan_word_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  kcl_in_if  in_ch ();
  kcl_out_if out_ch ();

  keypad_code_lock #(
    .CODE_LENGTH(KEYS_PER_ENTRY)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .entry   (in_ch),
    .result  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // words waiting to be offered, and outcomes of words already taken by the block
  scan_word_t    scan_words[$];
  lock_outcome_t pending_outcomes[$];

  // lock state as the predictor sees it
  logic [3:0] lk_keys[KEYS_PER_ENTRY];
  int         lk_count;
  logic [3:0] lk_fails;
  bit         lk_locked;
  logic [5:0] lk_elapsed;

  // register mirror
  logic [15:0] cfg_code;
  logic [3:0]  cfg_max_fail;
  logic [5:0]  cfg_lock_secs;

  int error_count;
  int live_words;
  int words_taken;
  int results_seen;
  int status_hits[8];
  int stall_cycles;
  bit quiet;

  // driver and monitor pacing
  int drv_gap;
  bit drv_calm;
  int mon_gap;
  bit mon_calm;
  int hold_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // one-cold nibble to line index, -1 when not one-cold
  function automatic int cold_line(input logic [3:0] nib);
    case (nib)
      4'b1110: return 0;
      4'b1101: return 1;
      4'b1011: return 2;
      4'b0111: return 3;
      default: return -1;
    endcase
  endfunction

  // scan byte for a key: row select in the low nibble, column select in the high one
  function automatic logic [7:0] key_scan(input logic [3:0] key);
    return {~(4'b0001 << key[1:0]), ~(4'b0001 << key[3:2])};
  endfunction

  // advances the lock state by one word and returns the status word it causes
  function automatic lock_outcome_t next_lock_outcome(input logic cmd, input logic [7:0] scan);
    lock_outcome_t r;
    int            row;
    int            col;
    bit            match;
    r = '{status: ST_NONE, key_position: 4'd0, failure_count: 4'd0, wait_elapsed: 6'd0};
    if (cmd == CMD_TICK) begin
      // ticks only matter during a lockout
      if (lk_locked) begin
        if (lk_elapsed < ELAPSED_MAX) lk_elapsed++;
        r.wait_elapsed = lk_elapsed;
        if (lk_elapsed >= cfg_lock_secs) begin
          lk_locked  = 1'b0;
          lk_elapsed = 6'd0;
          lk_fails   = 4'd0;
          r.status   = ST_LOCK_END;
        end else begin
          r.status = ST_LOCK_TICK;
        end
      end
    end else if (!lk_locked) begin
      row = cold_line(scan[3:0]);
      col = cold_line(scan[7:4]);
      if (row >= 0 && col >= 0) begin
        r.key_position = 4'(row * 4 + col);
        if (lk_count >= KEYS_PER_ENTRY) lk_count = 0;
        lk_keys[lk_count] = r.key_position;
        lk_count++;
        if (lk_count < KEYS_PER_ENTRY) begin
          r.status = ST_KEY;
        end else begin
          // every position has to match, not just the last one
          match = 1'b1;
          for (int i = 0; i < KEYS_PER_ENTRY; i++) begin
            if (lk_keys[i] != ((i < 4) ? cfg_code[4*i +: 4] : 4'd0)) match = 1'b0;
          end
          lk_count = 0;
          if (match) begin
            lk_fails = 4'd0;
            r.status = ST_RIGHT;
          end else begin
            if (lk_fails < 4'd15) lk_fails++;
            if (lk_fails >= cfg_max_fail) begin
              lk_locked  = 1'b1;
              lk_elapsed = 6'd0;
              r.status   = ST_LOCK_START;
            end else begin
              r.status = ST_WRONG;
            end
          end
        end
      end
    end
    r.failure_count = lk_fails;
    return r;
  endfunction

  // words are predicted as they are queued; config only changes when the block is drained
  task automatic queue_word(input logic cmd, input logic [7:0] scan);
    scan_word_t w;
    w.command   = cmd;
    w.scan_code = scan;
    w.outcome   = next_lock_outcome(cmd, scan);
    if (w.outcome.status != ST_NONE) live_words++;
    scan_words.push_back(w);
  endtask

  task automatic queue_entry(input logic [15:0] keys);
    for (int i = 0; i < KEYS_PER_ENTRY; i++) queue_word(CMD_SCAN, key_scan(keys[4*i +: 4]));
  endtask

  task automatic wait_drained();
    while (scan_words.size() != 0 || pending_outcomes.size() != 0) @(posedge clk);
  endtask

  // setup cycle, then access cycle; the register takes the value on the access edge
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_settings(input logic [15:0] code, input logic [3:0] max_fail,
                                input logic [5:0] secs);
    write_reg(REG_CODE_KEYS, 32'(code));
    write_reg(REG_MAX_FAILURES, 32'(max_fail));
    write_reg(REG_LOCKOUT_SECONDS, 32'(secs));
    cfg_code      = code;
    cfg_max_fail  = max_fail;
    cfg_lock_secs = secs;
  endtask

  // stimulus: directed words first, then phases of random entries under varied settings
  initial begin : stimulus
    logic [15:0] code;
    logic [3:0]  max_fail;
    logic [5:0]  secs;
    logic [15:0] bad;
    int          right_w;
    int          pick;
    int          live_goal;

    // every block input known from time zero
    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = 4'd0;
    pwdata          = 32'd0;
    in_ch.valid     = 1'b0;
    in_ch.command   = CMD_SCAN;
    in_ch.scan_code = 8'd0;
    out_ch.ready    = 1'b0;
    quiet           = 1'b0;

    // predictor mirrors the reset state
    foreach (lk_keys[i]) lk_keys[i] = 4'd0;
    lk_count      = 0;
    lk_fails      = 4'd0;
    lk_locked     = 1'b0;
    lk_elapsed    = 6'd0;
    cfg_code      = CODE_KEYS_RESET;
    cfg_max_fail  = MAX_FAILURES_RESET;
    cfg_lock_secs = LOCKOUT_SECONDS_RESET;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed, reset settings: idle byte, all-zero and all-one bytes are not keys
    queue_word(CMD_SCAN, 8'hF0);
    queue_word(CMD_SCAN, 8'h00);
    queue_word(CMD_SCAN, 8'hFF);
    // tick while unlocked does nothing
    queue_word(CMD_TICK, 8'hA5);
    // right entry with key 0 in it, then a wrong one of key 15
    queue_entry(CODE_KEYS_RESET);
    queue_entry(16'hFFFF);
    wait_drained();

    // shortest lockout: one failure locks, one tick frees; failure count already 1
    apply_settings(16'h0000, 4'd1, 6'd1);
    queue_entry(16'hFFFF);
    // key while locked is ignored
    queue_word(CMD_SCAN, key_scan(4'd5));
    queue_word(CMD_TICK, 8'h00);
    queue_entry(16'h0000);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          // slowest lockout, needs fifteen misses in a row
          code = 16'hFFFF; max_fail = 4'd15; secs = 6'd63; right_w = 2;
        end
        1: begin
          code = 16'h0000; max_fail = 4'd1; secs = 6'd63; right_w = 20;
        end
        2: begin
          code = 16'($urandom); max_fail = 4'd2; secs = 6'd1; right_w = 10;
        end
        default: begin
          code     = 16'($urandom);
          max_fail = $urandom_range(0, 1) ? 4'($urandom_range(1, 4)) : 4'($urandom_range(1, 15));
          secs     = $urandom_range(0, 1) ? 6'($urandom_range(1, 8)) : 6'($urandom_range(1, 63));
          right_w  = $urandom_range(5, 40);
        end
      endcase
      apply_settings(code, max_fail, secs);
      // last phase runs at full rate on both sides
      if (ph == PHASES - 1) quiet = 1'b1;

      live_goal = live_words + LIVE_PER_PHASE;
      while (live_words < live_goal) begin
        if (lk_locked) begin
          // mostly ticks to walk the lockout, some keys that must be ignored
          pick = $urandom_range(0, 99);
          if (pick < 80) queue_word(CMD_TICK, 8'($urandom));
          else if (pick < 92) queue_word(CMD_SCAN, key_scan(4'($urandom)));
          else queue_word(1'($urandom), 8'($urandom));
        end else begin
          pick = $urandom_range(0, 56 + right_w);
          if (pick < 30) begin
            // wrong entry, half of them off by one key only
            bad = $urandom_range(0, 1) ? 16'($urandom)
                : cfg_code ^ (16'($urandom_range(1, 15)) << (4 * $urandom_range(0, 3)));
            queue_entry(bad);
          end else if (pick < 45) begin
            // lone key shifts the alignment of later entries
            queue_word(CMD_SCAN, key_scan(4'($urandom)));
          end else if (pick < 53) begin
            queue_word(CMD_SCAN, 8'($urandom));
          end else if (pick < 57) begin
            queue_word(CMD_TICK, 8'($urandom));
          end else begin
            queue_entry(cfg_code);
          end
        end
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("checked %0d words in, %0d results out: %0d keys, %0d right, %0d wrong",
             words_taken, results_seen, status_hits[ST_KEY], status_hits[ST_RIGHT],
             status_hits[ST_WRONG]);
    $display("%0d lockouts started, %0d lockout ticks, %0d lockouts ended, %0d ignored words",
             status_hits[ST_LOCK_START], status_hits[ST_LOCK_TICK],
             status_hits[ST_LOCK_END], status_hits[ST_NONE]);
    if (error_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // driver: offers the front of scan_words, holds it until taken
  always @(posedge clk) begin : driver
    scan_word_t w;
    if (rst) begin
      in_ch.valid <= 1'b0;
      drv_gap = 0;
      drv_calm = 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        // word taken: its outcome is now owed by the block
        w = scan_words.pop_front();
        pending_outcomes.push_back(w.outcome);
        words_taken++;
      end
      // only change the offer when nothing is being held
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (!quiet && !drv_calm && drv_gap == 0 && $urandom_range(0, 3) == 0)
          drv_gap = $urandom_range(1, 6);
        if (drv_gap > 0 || scan_words.size() == 0) begin
          if (drv_gap > 0) drv_gap--;
          in_ch.valid <= 1'b0;
        end else begin
          in_ch.valid     <= 1'b1;
          in_ch.command   <= scan_words[0].command;
          in_ch.scan_code <= scan_words[0].scan_code;
        end
      end
      // calm stretches with no gaps at all
      if ($urandom_range(0, 49) == 0) drv_calm = !drv_calm;
    end
  end

  // monitor: checks each result word against the oldest owed outcome
  always @(posedge clk) begin : monitor
    lock_outcome_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
      mon_gap = 0;
      mon_calm = 1'b0;
      hold_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (pending_outcomes.size() == 0) begin
          report_error($sformatf("result word %0d with nothing expected, status %0d",
                                 results_seen, out_ch.status));
        end else begin
          want = pending_outcomes.pop_front();
          status_hits[int'(want.status)]++;
          if (out_ch.status !== want.status)
            report_error($sformatf("result %0d status %0d, expected %0d",
                                   results_seen, out_ch.status, want.status));
          if (out_ch.key_position !== want.key_position)
            report_error($sformatf("result %0d key_position %0d, expected %0d",
                                   results_seen, out_ch.key_position, want.key_position));
          if (out_ch.failure_count !== want.failure_count)
            report_error($sformatf("result %0d failure_count %0d, expected %0d",
                                   results_seen, out_ch.failure_count, want.failure_count));
          if (out_ch.wait_elapsed !== want.wait_elapsed)
            report_error($sformatf("result %0d wait_elapsed %0d, expected %0d",
                                   results_seen, out_ch.wait_elapsed, want.wait_elapsed));
        end
        // long back-pressure so the block's queue fills and it stalls its input
        if (results_seen == 300 || results_seen == 700) hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (!quiet && !mon_calm && mon_gap == 0 && $urandom_range(0, 3) == 0)
          mon_gap = $urandom_range(1, 6);
        if (mon_gap > 0) begin
          mon_gap--;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
      if ($urandom_range(0, 49) == 0) mon_calm = !mon_calm;
    end
  end

  // watchdog: too long with no word moving on any port means a hang
  always @(posedge clk) begin : watchdog
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d idle cycles, %0d results still owed",
               stall_cycles, pending_outcomes.size());
      $display("tb_top NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
